### sv/bas_pkg.sv
// Package: shared types, constants and the CORDIC arctangent table.
`timescale 1ns / 1ps
package bas_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int ANG_W = 32;
  localparam int SC_W = 34;   // sin/cos CORDIC datapath width
  localparam int AT_W = 36;   // atan2 CORDIC datapath width
  localparam int VEC_W = 34;  // atan2 operand width
  localparam int FRAC = 30;

  localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [ANG_W-1:0] RIGHT_ANGLE = 32'h4000_0000;
  localparam logic signed [SC_W-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [31:0] drone_latitude;
    logic signed [31:0] drone_longitude;
    logic signed [31:0] base_latitude;
    logic signed [31:0] base_longitude;
    logic signed [31:0] drone_heading;
    logic signed [31:0] camera_heading;
  } bas_in_t;

  typedef struct packed {
    logic        right_antenna;
    logic [31:0] relative_angle;
  } bas_out_t;

endpackage

### sv/bas_sincos.sv
// Pipelined rotation-mode CORDIC: cosine and sine of a binary angle in Q30.
`timescale 1ns / 1ps
module bas_sincos
  import bas_pkg::*;
#(
  parameter int N = CORDIC_STAGES_DEF,
  parameter int TAG_W = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_in,
  input  logic [ANG_W-1:0]        ang,
  input  logic [TAG_W-1:0]        tag_in,
  output logic                    vld_out,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o,
  output logic [TAG_W-1:0]        tag_out
);

  logic                   v_r   [0:N];
  logic signed [SC_W-1:0] x_r   [0:N];
  logic signed [SC_W-1:0] y_r   [0:N];
  logic signed [SC_W-1:0] z_r   [0:N];
  logic                   flp_r [0:N];
  logic [TAG_W-1:0]       tag_r [0:N];

  logic             flip;
  logic [ANG_W-1:0] fold;
  logic [ANG_W-1:0] qsum;

  assign qsum = ang + RIGHT_ANGLE;
  assign flip = qsum[ANG_W-1];
  assign fold = flip ? (ang - HALF_TURN) : ang;

  // fold into [-quarter, quarter)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vld_in;
    end
    if (en) begin
      x_r[0]   <= GAIN_Q30;
      y_r[0]   <= '0;
      z_r[0]   <= {{(SC_W-ANG_W){fold[ANG_W-1]}}, fold};
      flp_r[0] <= flip;
      tag_r[0] <= tag_in;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic signed [SC_W-1:0] dx, dy, da;
    assign dx = x_r[k-1] >>> (k-1);
    assign dy = y_r[k-1] >>> (k-1);
    assign da = $signed({{(SC_W-ANG_W){1'b0}}, ATAN_TAB[k-1]});
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        if (!z_r[k-1][SC_W-1]) begin
          x_r[k] <= x_r[k-1] - dy;
          y_r[k] <= y_r[k-1] + dx;
          z_r[k] <= z_r[k-1] - da;
        end else begin
          x_r[k] <= x_r[k-1] + dy;
          y_r[k] <= y_r[k-1] - dx;
          z_r[k] <= z_r[k-1] + da;
        end
        flp_r[k] <= flp_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  logic signed [SC_W-1:0] c_fin, s_fin;
  logic                   vo_r;
  logic signed [31:0]     c_r, s_r;
  logic [TAG_W-1:0]       to_r;

  assign c_fin = flp_r[N] ? -x_r[N] : x_r[N];
  assign s_fin = flp_r[N] ? -y_r[N] : y_r[N];

  // undo the half-turn fold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[N];
    end
    if (en) begin
      c_r  <= $signed(c_fin[31:0]);
      s_r  <= $signed(s_fin[31:0]);
      to_r <= tag_r[N];
    end
  end

  assign vld_out = vo_r;
  assign cos_o   = c_r;
  assign sin_o   = s_r;
  assign tag_out = to_r;

endmodule

### sv/bas_mult.sv
// Three-stage product network forming the atan2 operands from sines and cosines.
`timescale 1ns / 1ps
module bas_mult
  import bas_pkg::*;
#(
  parameter int TAG_W = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_in,
  input  logic signed [31:0]     sa,
  input  logic signed [31:0]     ca,
  input  logic signed [31:0]     sb,
  input  logic signed [31:0]     cb,
  input  logic signed [31:0]     sd,
  input  logic signed [31:0]     cd,
  input  logic [TAG_W-1:0]       tag_in,
  output logic                   vld_out,
  output logic signed [VEC_W-1:0] vy,
  output logic signed [VEC_W-1:0] vx,
  output logic [TAG_W-1:0]       tag_out
);

  logic               v1_r, v2_r, v3_r;
  logic signed [63:0] p1_r, p2_r, p3_r;
  logic signed [31:0] cd_r;
  logic [TAG_W-1:0]   t1_r, t2_r, t3_r;

  logic signed [64:0] t_r;
  logic signed [32:0] vy2_r;
  logic signed [32:0] q_r;
  logic signed [VEC_W-1:0] vy3_r, vx3_r;

  logic signed [63:0] p1_sh, p2_sh, p3_sh;
  logic signed [32:0] p2_q;
  logic signed [64:0] t_sh;
  logic signed [VEC_W-1:0] t_q;

  assign p1_sh = p1_r >>> FRAC;
  assign p2_sh = p2_r >>> FRAC;
  assign p3_sh = p3_r >>> FRAC;
  assign p2_q  = $signed(p2_sh[32:0]);
  assign t_sh  = t_r >>> FRAC;
  assign t_q   = $signed(t_sh[VEC_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (en) begin
      p1_r  <= sd * cb;
      p2_r  <= sa * cb;
      p3_r  <= ca * sb;
      cd_r  <= cd;
      t1_r  <= tag_in;
      // three-factor term: second product
      t_r   <= p2_q * cd_r;
      vy2_r <= $signed(p1_sh[32:0]);
      q_r   <= $signed(p3_sh[32:0]);
      t2_r  <= t1_r;
      vy3_r <= {vy2_r[32], vy2_r};
      vx3_r <= {q_r[32], q_r} - t_q;
      t3_r  <= t2_r;
    end
  end

  assign vld_out = v3_r;
  assign vy      = vy3_r;
  assign vx      = vx3_r;
  assign tag_out = t3_r;

endmodule

### sv/bas_atan2.sv
// Pipelined vectoring-mode CORDIC: atan2 as a binary angle.
`timescale 1ns / 1ps
module bas_atan2
  import bas_pkg::*;
#(
  parameter int N = CORDIC_STAGES_DEF,
  parameter int TAG_W = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_in,
  input  logic signed [VEC_W-1:0] vy,
  input  logic signed [VEC_W-1:0] vx,
  input  logic [TAG_W-1:0]        tag_in,
  output logic                    vld_out,
  output logic [ANG_W-1:0]        ang,
  output logic [TAG_W-1:0]        tag_out
);

  logic                   v_r   [0:N];
  logic signed [AT_W-1:0] x_r   [0:N];
  logic signed [AT_W-1:0] y_r   [0:N];
  logic [ANG_W-1:0]       z_r   [0:N];
  logic                   zer_r [0:N];
  logic [TAG_W-1:0]       tag_r [0:N];

  logic signed [AT_W-1:0] xe, ye;
  assign xe = {{(AT_W-VEC_W){vx[VEC_W-1]}}, vx};
  assign ye = {{(AT_W-VEC_W){vy[VEC_W-1]}}, vy};

  // move the vector into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vld_in;
    end
    if (en) begin
      x_r[0]   <= vx[VEC_W-1] ? -xe : xe;
      y_r[0]   <= vx[VEC_W-1] ? -ye : ye;
      z_r[0]   <= vx[VEC_W-1] ? HALF_TURN : '0;
      zer_r[0] <= (vx == '0) && (vy == '0);
      tag_r[0] <= tag_in;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic signed [AT_W-1:0] dx, dy;
    assign dx = x_r[k-1] >>> (k-1);
    assign dy = y_r[k-1] >>> (k-1);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        if (y_r[k-1][AT_W-1]) begin
          x_r[k] <= x_r[k-1] - dy;
          y_r[k] <= y_r[k-1] + dx;
          z_r[k] <= z_r[k-1] - ATAN_TAB[k-1];
        end else begin
          x_r[k] <= x_r[k-1] + dy;
          y_r[k] <= y_r[k-1] - dx;
          z_r[k] <= z_r[k-1] + ATAN_TAB[k-1];
        end
        zer_r[k] <= zer_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  // zero vector gives a zero angle
  assign vld_out = v_r[N];
  assign ang     = zer_r[N] ? '0 : z_r[N];
  assign tag_out = tag_r[N];

endmodule

### sv/bearing_antenna_selector_unit.sv
// Top level: bearing antenna selector pipeline.
`timescale 1ns / 1ps
// Computes the great-circle forward azimuth from the drone to the base
// station, subtracts drone and camera yaw, and selects the right antenna when
// the camera-frame angle lies strictly between zero and a half turn (the left
// antenna otherwise, including exactly zero and exactly a half turn). All
// angles are 32-bit binary angles, 2^32 per turn. The block is a fully
// pipelined datapath: one beat can enter every clock while the output is not
// stalled. Each beat passes through the two unrolled CORDICs (sine/cosine:
// fold, stages and sign fix; atan2: half-plane move and stages), three
// product stages and the output register. The whole pipe advances whenever
// the output register is empty or being taken, so a stall at the output
// holds every stage in place.
module bearing_antenna_selector_unit
  import bas_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bas_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bas_out_t out_data
);

  logic en;
  logic out_valid_r, out_valid_nxt;
  bas_out_t out_data_r, out_data_nxt;

  // advance when the output register is free or draining this cycle
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  logic [ANG_W-1:0] dlon, yaw_sum;
  assign dlon    = in_data.base_longitude - in_data.drone_longitude;
  assign yaw_sum = in_data.drone_heading + in_data.camera_heading;

  logic               sc_vld, sc_vld_a, sc_vld_b;
  logic signed [31:0] ca, sa, cb, sb, cd, sd;
  logic [ANG_W-1:0]   yaw_sc, yaw_mu, yaw_at;
  logic [0:0]         unused_a, unused_b;

  // yaw sum rides along with the longitude difference
  bas_sincos #(.N(CORDIC_STAGES), .TAG_W(ANG_W)) u_sc_d (
    .clk, .rst_n, .en, .vld_in(in_valid && in_ready), .ang(dlon),
    .tag_in(yaw_sum), .vld_out(sc_vld), .cos_o(cd), .sin_o(sd), .tag_out(yaw_sc)
  );
  bas_sincos #(.N(CORDIC_STAGES), .TAG_W(1)) u_sc_a (
    .clk, .rst_n, .en, .vld_in(in_valid && in_ready),
    .ang(in_data.drone_latitude), .tag_in(1'b0), .vld_out(sc_vld_a),
    .cos_o(ca), .sin_o(sa), .tag_out(unused_a)
  );
  bas_sincos #(.N(CORDIC_STAGES), .TAG_W(1)) u_sc_b (
    .clk, .rst_n, .en, .vld_in(in_valid && in_ready),
    .ang(in_data.base_latitude), .tag_in(1'b0), .vld_out(sc_vld_b),
    .cos_o(cb), .sin_o(sb), .tag_out(unused_b)
  );

  logic                    mu_vld;
  logic signed [VEC_W-1:0] vy, vx;

  bas_mult #(.TAG_W(ANG_W)) u_mult (
    .clk, .rst_n, .en, .vld_in(sc_vld), .sa, .ca, .sb, .cb, .sd, .cd,
    .tag_in(yaw_sc), .vld_out(mu_vld), .vy, .vx, .tag_out(yaw_mu)
  );

  logic             at_vld;
  logic [ANG_W-1:0] bearing;

  bas_atan2 #(.N(CORDIC_STAGES), .TAG_W(ANG_W)) u_atan (
    .clk, .rst_n, .en, .vld_in(mu_vld), .vy, .vx, .tag_in(yaw_mu),
    .vld_out(at_vld), .ang(bearing), .tag_out(yaw_at)
  );

  logic [ANG_W-1:0] rel;
  assign rel = bearing - yaw_at;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (en) begin
      out_valid_nxt               = at_vld;
      out_data_nxt.relative_angle = rel;
      out_data_nxt.right_antenna  = (rel != '0) && !rel[ANG_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the three CORDIC lanes stay in lock step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (sc_vld == sc_vld_a) && (sc_vld == sc_vld_b))
    else $error("sin/cos lanes out of step");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while output stalled");

  a_antenna_matches_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.right_antenna ==
      ((out_data.relative_angle != '0) && !out_data.relative_angle[ANG_W-1])))
    else $error("antenna select disagrees with relative angle");

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

### dv/bearing_antenna_selector_unit_tb.sv
// Testbench for the bearing antenna selector: directed and random beats checked against a predictor.
`timescale 1ns / 1ps
module bearing_antenna_selector_unit_tb;
  import bas_pkg::*;

  // Pipeline depth of the block at its default stage count; used for the
  // drain wait at the end and to size the hold-off stretch.
  localparam int PIPE_LAT = 2 * CORDIC_STAGES_DEF + 7;
  localparam int N_RANDOM = 1880;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  bas_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  bas_out_t out_data;

  bas_in_t  pending_beats[$];
  bas_out_t expected_angles[$];
  int       err_count = 0;
  int       send_idle_pct = 37;
  int       recv_idle_pct = 73;
  int       hold_off_cycles = 0;

  bearing_antenna_selector_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Floor shift of a signed value; >>> on a signed longint is arithmetic.
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  // Rotation CORDIC: cosine and sine of a binary angle in Q30.
  function automatic void rot_sincos(input logic [31:0] ang, output longint c,
                                     output longint s);
    logic [31:0] r;
    logic [31:0] tmp;
    bit          flip;
    longint      z, x, y, dx, dy;
    tmp  = ang + RIGHT_ANGLE;
    flip = tmp[31];
    r    = flip ? ang - HALF_TURN : ang;
    z    = longint'($signed(r));
    x    = GAIN_Q30;
    y    = 0;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Vectoring CORDIC: binary-angle atan2, zero for the zero vector.
  function automatic logic [31:0] vec_atan2(longint y, longint x);
    logic [31:0] z;
    longint      dx, dy;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x; y = -y; z = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y < 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  // Bearing to base, moved into the camera frame, plus the antenna choice.
  function automatic bas_out_t predict_antenna(bas_in_t b);
    longint      ca, sa, cb, sb, cd, sd, vy, vx, t;
    logic [31:0] bearing, rel;
    bas_out_t    r;
    rot_sincos(b.drone_latitude, ca, sa);
    rot_sincos(b.base_latitude, cb, sb);
    rot_sincos(b.base_longitude - b.drone_longitude, cd, sd);
    vy = fshr(sd * cb, 30);
    t  = fshr(fshr(sa * cb, 30) * cd, 30);
    vx = fshr(ca * sb, 30) - t;
    bearing = vec_atan2(vy, vx);
    rel = bearing - b.drone_heading - b.camera_heading;
    r.relative_angle = rel;
    r.right_antenna  = (rel != 0) && (rel < HALF_TURN);
    return r;
  endfunction

  function automatic bas_in_t mk_beat(logic [31:0] la, logic [31:0] loa, logic [31:0] lb,
                                      logic [31:0] lob, logic [31:0] yd, logic [31:0] yc);
    bas_in_t b;
    b.drone_latitude  = la;
    b.drone_longitude = loa;
    b.base_latitude   = lb;
    b.base_longitude  = lob;
    b.drone_heading   = yd;
    b.camera_heading  = yc;
    return b;
  endfunction

  function automatic logic [31:0] rand_lat();
    return $urandom_range(2) == 0 ? $urandom()
         : 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
  endfunction

  // Driver: hold the beat until taken, then advance or idle at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict at acceptance so expectations stay in beat order.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) expected_angles.push_back(predict_antenna(in_data));
  end

  // Monitor: compare each taken result with the oldest prediction.
  always @(posedge clk) begin
    bas_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_angles.size() == 0) begin
        $error("result with no expectation: %h", out_data);
        err_count++;
      end else begin
        exp_r = expected_angles.pop_front();
        if (out_data.right_antenna !== exp_r.right_antenna) begin
          $error("right_antenna expected %0d actual %0d", exp_r.right_antenna,
                 out_data.right_antenna);
          err_count++;
        end
        if (out_data.relative_angle !== exp_r.relative_angle) begin
          $error("relative_angle expected %h actual %h", exp_r.relative_angle,
                 out_data.relative_angle);
          err_count++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off while the sender keeps going.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [31:0] ext[6];
    in_data = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, zero vector, poles, boundary angles.
    ext = '{32'h0, 32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    pending_beats.push_back(mk_beat(0, 0, 0, 0, 0, 0));
    pending_beats.push_back(mk_beat(32'h4000_0000, 0, 32'h4000_0000, 0, 0, 0));
    pending_beats.push_back(mk_beat(32'hC000_0000, 32'h8000_0000, 32'h4000_0000,
                                    32'h7FFF_FFFF, 0, 0));
    pending_beats.push_back(mk_beat(0, 0, 32'h1000_0000, 0, 32'h8000_0000, 0));
    pending_beats.push_back(mk_beat(0, 0, 0, 32'h1000_0000, 32'h4000_0000, 0));
    pending_beats.push_back(mk_beat(0, 0, 0, 32'h1000_0000, 32'h3000_0000, 32'h1000_0000));
    pending_beats.push_back(mk_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_beats.push_back(mk_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                                    32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000));
    for (int k = 0; k < 12; k++)
      pending_beats.push_back(mk_beat(ext[$urandom_range(5)], ext[$urandom_range(5)],
                                      ext[$urandom_range(5)], ext[$urandom_range(5)],
                                      ext[$urandom_range(5)], ext[$urandom_range(5)]));

    // Random: three idling phases; the first carries a long output hold-off.
    for (int ph = 0; ph < 3; ph++) begin
      for (int k = 0; k < N_RANDOM / 3; k++)
        pending_beats.push_back(mk_beat(rand_lat(), $urandom(), rand_lat(), $urandom(),
                                        $urandom(), $urandom()));
      if (ph == 0) hold_off_cycles <= 4 * PIPE_LAT;
      wait (pending_beats.size() == 0);
      @(posedge clk);
      wait (!in_valid);
      send_idle_pct = (ph == 0) ? 73 : 0;
      recv_idle_pct = (ph == 0) ? 37 : 0;
    end
    wait (expected_angles.size() == 0);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (err_count == 0) begin
      $display("** bearing_antenna_selector_unit: PASSED **");
    end else begin
      $display("** bearing_antenna_selector_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** bearing_antenna_selector_unit: FAILED **");
    $finish;
  end

endmodule
